/* hdl/hff_pkg.sv */
`timescale 1ns / 1ps

package hff_pkg;

	// Length modifier codes
	localparam logic [1:0] LEN_NONE = 2'd0;  // 32 bit
	localparam logic [1:0] LEN_HH   = 2'd1;  // 8 bit
	localparam logic [1:0] LEN_H    = 2'd2;  // 16 bit
	localparam logic [1:0] LEN_L    = 2'd3;  // 64 bit

	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned NIBBLES  = VALUE_W / 4;
	localparam int unsigned DIG_W    = $clog2(NIBBLES + 1);

	// Largest precision honoured; keeps the text within 63 characters
	localparam logic [5:0] PREC_CAP = 6'd61;

	// ASCII codes
	localparam logic [6:0] CH_SPACE   = 7'h20;
	localparam logic [6:0] CH_ZERO    = 7'h30;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_LOWER_A = 7'h61;
	localparam logic [6:0] CH_UPPER_X = 7'h58;
	localparam logic [6:0] CH_LOWER_X = 7'h78;

	// Controls from the sequencer to the shift unit
	typedef struct packed {
		logic load;
		logic shift;
	} sh_ctl_t;

	// Status from the shift unit back to the sequencer
	typedef struct packed {
		logic [3:0] top_nib;
		logic       is_zero;
	} sh_stat_t;

	// Map one nibble to its ASCII hex digit
	function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [6:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (nib < 4'd10)
			return CH_ZERO + {3'b000, nib};
		else
			return base + {3'b000, nib} - 7'd10;
	endfunction

endpackage

/* hdl/hff_if.sv */
`timescale 1ns / 1ps

// Conversion request channel
interface hff_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  length_mod;
	logic        upper_case;
	logic        alt_form;
	logic        zero_pad;
	logic        left_align;
	logic [5:0]  field_width;
	logic        precision_given;
	logic [5:0]  min_digits;

	modport source (
		output valid, value, length_mod, upper_case, alt_form, zero_pad,
		       left_align, field_width, precision_given, min_digits,
		input  ready
	);
	modport sink (
		input  valid, value, length_mod, upper_case, alt_form, zero_pad,
		       left_align, field_width, precision_given, min_digits,
		output ready
	);
endinterface

// Character stream channel
interface hff_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_out;
	logic       last_char;

	modport source (output valid, char_out, last_char, input ready);
	modport sink   (input valid, char_out, last_char, output ready);
endinterface

/* hdl/hff_shifter.sv */
`timescale 1ns / 1ps

module hff_shifter (
	input  logic              clk,
	input  hff_pkg::sh_ctl_t  ctl,
	input  logic [63:0]       load_val,
	output hff_pkg::sh_stat_t stat
);
	import hff_pkg::*;

	logic [VALUE_W-1:0] sh_q;

	// Load the cut value, or move it up by one nibble
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q <= load_val;
		end else if (ctl.shift) begin
			sh_q <= {sh_q[VALUE_W-5:0], 4'h0};
		end
	end

	assign stat.top_nib = sh_q[VALUE_W-1 -: 4];
	assign stat.is_zero = (sh_q == '0);

endmodule

/* hdl/hff_seq.sv */
`timescale 1ns / 1ps

module hff_seq (
	input  logic              clk,
	input  logic              arst_n,
	hff_in_if.sink            in_ch,
	hff_out_if.source         out_ch,
	output hff_pkg::sh_ctl_t  sh_ctl,
	output logic [63:0]       sh_load,
	input  hff_pkg::sh_stat_t sh_stat
);
	import hff_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_NORM, ST_PLAN, ST_LEAD, ST_PFX0, ST_PFX1, ST_ZERO, ST_DIG, ST_TRAIL
	} state_t;

	state_t           state_q;
	logic             upper_q, alt_q, zf_q, left_q, pgiven_q, vzero_q, pfx_q;
	logic [5:0]       width_q, prec_q;
	logic [DIG_W-1:0] dig_q;
	logic [5:0]       lead_q, zcnt_q, trail_q, rem_q;
	logic             out_valid_q, last_q;
	logic [6:0]       char_q;

	logic             in_xfer, slot_free, emit;
	logic [6:0]       emit_char;
	logic [5:0]       prec_eff, body, pad, outs;
	logic [6:0]       total, zsum;
	logic             pfx;

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign in_xfer          = in_ch.valid && in_ch.ready;
	assign slot_free        = !out_valid_q || out_ch.ready;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.char_out  = char_q;
	assign out_ch.last_char = last_q;

	// Cut the value to the length modifier
	always_comb begin
		unique case (in_ch.length_mod)
			LEN_HH:   sh_load = {56'd0, in_ch.value[7:0]};
			LEN_H:    sh_load = {48'd0, in_ch.value[15:0]};
			LEN_NONE: sh_load = {32'd0, in_ch.value[31:0]};
			LEN_L:    sh_load = in_ch.value;
			default:  sh_load = in_ch.value;
		endcase
	end

	// Work out the field layout from the digit count
	always_comb begin
		if (!pgiven_q)
			prec_eff = 6'd1;
		else if (prec_q > PREC_CAP)
			prec_eff = PREC_CAP;
		else
			prec_eff = prec_q;
		body  = (prec_eff > {1'b0, dig_q}) ? prec_eff : {1'b0, dig_q};
		pfx   = alt_q && !vzero_q;
		total = {1'b0, body} + (pfx ? 7'd2 : 7'd0);
		if ({1'b0, width_q} > total) begin
			pad  = width_q - total[5:0];
			outs = width_q;
		end else begin
			pad  = 6'd0;
			outs = total[5:0];
		end
		zsum = (zf_q ? {1'b0, pad} : 7'd0) + {1'b0, body} - {2'b00, dig_q};
	end

	// Pick the character for the active segment
	always_comb begin
		emit      = 1'b0;
		emit_char = CH_SPACE;
		unique case (state_q)
			ST_LEAD: begin
				emit      = slot_free && (lead_q != 6'd0);
				emit_char = CH_SPACE;
			end
			ST_PFX0: begin
				emit      = slot_free && pfx_q;
				emit_char = CH_ZERO;
			end
			ST_PFX1: begin
				emit      = slot_free && pfx_q;
				emit_char = upper_q ? CH_UPPER_X : CH_LOWER_X;
			end
			ST_ZERO: begin
				emit      = slot_free && (zcnt_q != 6'd0);
				emit_char = CH_ZERO;
			end
			ST_DIG: begin
				emit      = slot_free && (dig_q != '0);
				emit_char = hex_char(sh_stat.top_nib, upper_q);
			end
			ST_TRAIL: begin
				emit      = slot_free && (trail_q != 6'd0);
				emit_char = CH_SPACE;
			end
			default: begin
				emit      = 1'b0;
				emit_char = CH_SPACE;
			end
		endcase
	end

	// Drive the shared shift unit
	assign sh_ctl.load  = in_xfer;
	assign sh_ctl.shift = ((state_q == ST_NORM) && !sh_stat.is_zero && (sh_stat.top_nib == 4'h0))
	                      || ((state_q == ST_DIG) && emit);

	// Hold state, segment counts and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			upper_q     <= 1'b0;
			alt_q       <= 1'b0;
			zf_q        <= 1'b0;
			left_q      <= 1'b0;
			pgiven_q    <= 1'b0;
			vzero_q     <= 1'b0;
			pfx_q       <= 1'b0;
			width_q     <= 6'd0;
			prec_q      <= 6'd0;
			dig_q       <= '0;
			lead_q      <= 6'd0;
			zcnt_q      <= 6'd0;
			trail_q     <= 6'd0;
			rem_q       <= 6'd0;
			last_q      <= 1'b0;
			char_q      <= CH_SPACE;
		end else begin
			// Release the output register once taken
			if (emit) begin
				out_valid_q <= 1'b1;
				char_q      <= emit_char;
				last_q      <= (rem_q == 6'd1);
				rem_q       <= rem_q - 6'd1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						upper_q  <= in_ch.upper_case;
						alt_q    <= in_ch.alt_form;
						zf_q     <= in_ch.zero_pad && !in_ch.left_align && !in_ch.precision_given;
						left_q   <= in_ch.left_align;
						pgiven_q <= in_ch.precision_given;
						width_q  <= in_ch.field_width;
						prec_q   <= in_ch.min_digits;
						dig_q    <= DIG_W'(NIBBLES);
						state_q  <= ST_NORM;
					end
				end
				ST_NORM: begin
					// Drop leading zero nibbles
					if (sh_stat.is_zero) begin
						vzero_q <= 1'b1;
						dig_q   <= '0;
						state_q <= ST_PLAN;
					end else if (sh_stat.top_nib == 4'h0) begin
						dig_q <= dig_q - DIG_W'(1);
					end else begin
						vzero_q <= 1'b0;
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					pfx_q   <= pfx;
					lead_q  <= (!left_q && !zf_q) ? pad : 6'd0;
					zcnt_q  <= zsum[5:0];
					trail_q <= left_q ? pad : 6'd0;
					rem_q   <= outs;
					state_q <= (outs == 6'd0) ? ST_IDLE : ST_LEAD;
				end
				ST_LEAD: begin
					if (lead_q == 6'd0)
						state_q <= ST_PFX0;
					else if (emit) begin
						lead_q <= lead_q - 6'd1;
						if (rem_q == 6'd1)
							state_q <= ST_IDLE;
					end
				end
				ST_PFX0: begin
					if (!pfx_q)
						state_q <= ST_ZERO;
					else if (emit)
						state_q <= ST_PFX1;
				end
				ST_PFX1: begin
					if (emit)
						state_q <= (rem_q == 6'd1) ? ST_IDLE : ST_ZERO;
				end
				ST_ZERO: begin
					if (zcnt_q == 6'd0)
						state_q <= ST_DIG;
					else if (emit) begin
						zcnt_q <= zcnt_q - 6'd1;
						if (rem_q == 6'd1)
							state_q <= ST_IDLE;
					end
				end
				ST_DIG: begin
					if (dig_q == '0)
						state_q <= ST_TRAIL;
					else if (emit) begin
						dig_q <= dig_q - DIG_W'(1);
						if (rem_q == 6'd1)
							state_q <= ST_IDLE;
					end
				end
				ST_TRAIL: begin
					if (trail_q == 6'd0)
						state_q <= ST_IDLE;
					else if (emit) begin
						trail_q <= trail_q - 6'd1;
						if (rem_q == 6'd1)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/hex_field_formatter_top.sv */
`timescale 1ns / 1ps

// Hex field formatter: printf %x / %X conversion, one ASCII character per transfer.
// in_ch takes one value with its spec (length modifier, case, flags #, 0, -,
// field width and precision). out_ch returns the formatted text, one character
// per transfer, with last_char set on the final one; an empty field gives none.
// Sequence: the transfer on in_ch is followed by a leading-zero search in the
// shared nibble shifter, one nibble a cycle, then a planning state, then one
// character per cycle into the output register while the receiver keeps up,
// with a step of its own to close each counted segment or to skip an empty one
// (up to four per conversion). Up to 63 characters are produced.
// in_ch.ready is high only while no conversion is in progress; the next value is
// taken while the final character still waits in the output register.
// If the receiver stalls, the output register holds its character and the
// sequencer waits. Reset clears the sequencer and the output valid at once.
module hex_field_formatter_top (
	input  logic      clk,
	input  logic      arst_n,
	hff_in_if.sink    in_ch,
	hff_out_if.source out_ch
);
	import hff_pkg::*;

	sh_ctl_t     sh_ctl;
	sh_stat_t    sh_stat;
	logic [63:0] sh_load;

	hff_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.sh_ctl  (sh_ctl),
		.sh_load (sh_load),
		.sh_stat (sh_stat)
	);

	hff_shifter u_shifter (
		.clk      (clk),
		.ctl      (sh_ctl),
		.load_val (sh_load),
		.stat     (sh_stat)
	);

endmodule

/* hdl/hff_checker.sv */
`timescale 1ns / 1ps

module hff_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] char_out,
	input logic       last_char
);

	// A stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last_char))
		else $error("stalled output character changed");

	// A stalled valid is not withdrawn
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// A new conversion keeps the input closed in the next cycle
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// Mid-text the input stays closed
	a_busy_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |-> !in_ready)
		else $error("input ready while a conversion is still emitting");

endmodule

bind hex_field_formatter_top hff_checker u_hff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.char_out  (out_ch.char_out),
	.last_char (out_ch.last_char)
);
